FILE: sv/rbs_pkg.sv
// Package for ray_box_slab_test: default widths and hit_epsilon register constants.
// No dependencies.
`default_nettype none
package rbs_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int EPS_WIDTH       = 17;
    localparam logic [EPS_WIDTH-1:0] EPS_RESET = 17'd7;
endpackage
`default_nettype wire

FILE: sv/ray_box_slab_test.sv
// Ray / axis-aligned box slab test, signed fixed point, fully pipelined.
// Depends on rbs_pkg.
// Stages from start to o_valid: one input stage, one pipelined divider stage
// per quotient bit (six lanes in parallel), one saturation stage and two
// interval compare stages.
// Throughput: one word per cycle; o_busy stays low. Results cannot be stalled.
// Reset (synchronous, active low) clears the valid pipeline and sets hit_epsilon to 7.
`default_nettype none
module ray_box_slab_test #(
    parameter int COORD_WIDTH = rbs_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rbs_pkg::FRAC_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    output logic                           o_busy,
    input  wire                            i_hit_epsilon_we,
    input  wire [rbs_pkg::EPS_WIDTH-1:0]   i_hit_epsilon,
    input  wire signed [COORD_WIDTH-1:0]   i_origin_x,
    input  wire signed [COORD_WIDTH-1:0]   i_origin_y,
    input  wire signed [COORD_WIDTH-1:0]   i_origin_z,
    input  wire signed [COORD_WIDTH-1:0]   i_dir_x,
    input  wire signed [COORD_WIDTH-1:0]   i_dir_y,
    input  wire signed [COORD_WIDTH-1:0]   i_dir_z,
    input  wire signed [COORD_WIDTH-1:0]   i_box_min_x,
    input  wire signed [COORD_WIDTH-1:0]   i_box_min_y,
    input  wire signed [COORD_WIDTH-1:0]   i_box_min_z,
    input  wire signed [COORD_WIDTH-1:0]   i_box_max_x,
    input  wire signed [COORD_WIDTH-1:0]   i_box_max_y,
    input  wire signed [COORD_WIDTH-1:0]   i_box_max_z,
    output logic                           o_valid,
    output logic                           o_is_hit
);
    localparam int W    = COORD_WIDTH;
    localparam int NW   = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int NSTG = NW + 4;
    localparam int EW   = rbs_pkg::EPS_WIDTH;
    localparam int CMPW = (W + 1 > EW + 1) ? W + 1 : EW + 1;
    localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W:0] POS_INF = {1'b0, {W{1'b1}}};
    localparam logic signed [W:0] NEG_INF = {1'b1, {W{1'b0}}};

    typedef struct packed {
        logic [NW-1:0] nq;
        logic [W:0]    rem;
        logic [W-1:0]  dm;
        logic          zden;
        logic          nzero;
        logic          nneg;
        logic          qneg;
    } t_lane;

    logic signed [W-1:0] org [0:2];
    logic signed [W-1:0] dir [0:2];
    logic signed [W-1:0] bmn [0:2];
    logic signed [W-1:0] bmx [0:2];

    assign org = '{i_origin_x, i_origin_y, i_origin_z};
    assign dir = '{i_dir_x, i_dir_y, i_dir_z};
    assign bmn = '{i_box_min_x, i_box_min_y, i_box_min_z};
    assign bmx = '{i_box_max_x, i_box_max_y, i_box_max_z};

    logic                  accept;
    logic [EW-1:0]         r_eps;
    logic [NSTG-1:0]       r_vld;
    t_lane                 n_in   [0:5];
    t_lane                 r_div  [0:NW][0:5];
    logic signed [W:0]     n_t    [0:5];
    logic signed [W:0]     r_t    [0:5];
    logic                  r_rej1;
    logic signed [W:0]     r_min1;
    logic signed [W:0]     r_max1;
    logic signed [W:0]     r_za;
    logic signed [W:0]     r_zb;
    logic                  n_rej1;
    logic signed [W:0]     n_min1;
    logic signed [W:0]     n_max1;
    logic                  n_hit;
    logic                  r_hit;

    assign accept   = i_start && !o_busy;
    assign o_busy   = 1'b0;
    assign o_valid  = r_vld[NSTG-1];
    assign o_is_hit = r_hit;

    function automatic t_lane div_step(input t_lane a);
        t_lane     r;
        logic [W:0] t;
        r = a;
        t = {a.rem[W-1:0], a.nq[NW-1]};
        if (t >= {1'b0, a.dm}) begin
            r.rem = t - {1'b0, a.dm};
            r.nq  = {a.nq[NW-2:0], 1'b1};
        end else begin
            r.rem = t;
            r.nq  = {a.nq[NW-2:0], 1'b0};
        end
        return r;
    endfunction

    // lane 2*axis is the entry plane, 2*axis+1 the exit plane
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            logic signed [W-1:0] pl;
            logic signed [W:0]   df;
            logic [W:0]          mg;
            pl = (dir[k/2][W-1] ^ k[0]) ? bmx[k/2] : bmn[k/2];
            df = {pl[W-1], pl} - {org[k/2][W-1], org[k/2]};
            mg = df[W] ? -df : df;
            n_in[k].nq    = {mg, {FRAC_BITS{1'b0}}};
            n_in[k].rem   = '0;
            n_in[k].dm    = dir[k/2][W-1] ? -dir[k/2] : dir[k/2];
            n_in[k].zden  = (dir[k/2] == '0);
            n_in[k].nzero = (mg == '0);
            n_in[k].nneg  = df[W];
            n_in[k].qneg  = df[W] ^ dir[k/2][W-1];
        end
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            t_lane      l;
            logic [W:0] mg;
            l  = r_div[NW][k];
            mg = (|l.nq[NW-1:W-1]) ? {1'b0, MAXV} : {2'b00, l.nq[W-2:0]};
            if (l.zden) begin
                if (l.nzero) begin
                    n_t[k] = k[0] ? POS_INF : NEG_INF;
                end else begin
                    n_t[k] = l.nneg ? -$signed({1'b0, MAXV}) : $signed({1'b0, MAXV});
                end
            end else begin
                n_t[k] = l.qneg ? -$signed(mg) : $signed(mg);
            end
        end
    end

    always_comb begin
        n_rej1 = (r_t[0] > r_t[3]) || (r_t[2] > r_t[1]);
        n_min1 = (r_t[2] > r_t[0]) ? r_t[2] : r_t[0];
        n_max1 = (r_t[1] > r_t[3]) ? r_t[3] : r_t[1];
    end

    always_comb begin
        logic signed [W:0]      fmax;
        logic signed [CMPW-1:0] fx;
        logic signed [CMPW-1:0] ne;
        fmax  = (r_max1 > r_zb) ? r_zb : r_max1;
        fx    = CMPW'(fmax);
        ne    = -$signed(CMPW'({1'b0, r_eps}));
        n_hit = !r_rej1 && !(r_min1 > r_zb) && !(r_za > r_max1) && (fx > ne);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_eps <= rbs_pkg::EPS_RESET;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], accept};
            if (i_hit_epsilon_we) begin
                r_eps <= i_hit_epsilon;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 6; k++) begin
            r_div[0][k] <= n_in[k];
            for (int s = 1; s <= NW; s++) begin
                r_div[s][k] <= div_step(r_div[s-1][k]);
            end
            r_t[k] <= n_t[k];
        end
        r_rej1 <= n_rej1;
        r_min1 <= n_min1;
        r_max1 <= n_max1;
        r_za   <= r_t[4];
        r_zb   <= r_t[5];
        r_hit  <= n_hit;
    end

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##(NSTG) o_valid) else $error("result missing after accept");
    a_noinv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |-> ##(NSTG) !o_valid) else $error("result without accepted word");
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid after reset");
    a_eps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_hit_epsilon_we |=> $stable(r_eps)) else $error("epsilon changed without write");
endmodule
`default_nettype wire

FILE: sim/tb_ray_box_slab_test.sv
// Testbench for ray_box_slab_test: directed table plus random ray/box words,
// checked against a behavioral slab-method predictor. Depends on rbs_pkg and the DUT.
`timescale 1ns / 100ps
module tb_ray_box_slab_test;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int EW = rbs_pkg::EPS_WIDTH;
    localparam longint MAXV = 64'sh7FFF_FFFF;
    localparam int LAT = CW + FB + 5;
    localparam logic signed [CW-1:0] ONE = 32'sh1_0000;
    localparam logic signed [CW-1:0] MN = 32'sh8000_0000;
    localparam logic signed [CW-1:0] MX = 32'sh7FFF_FFFF;

    typedef struct {
        logic signed [CW-1:0] o [3];
        logic signed [CW-1:0] d [3];
        logic signed [CW-1:0] mn [3];
        logic signed [CW-1:0] mx [3];
    } ray_box_t;

    typedef struct {
        int lvl;
        longint v;
    } dist_t;

    typedef struct {
        ray_box_t w;
        int hit;
    } test_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    logic o_busy;
    logic i_hit_epsilon_we = 1'b0;
    logic [EW-1:0] i_hit_epsilon = '0;
    ray_box_t drv;
    logic o_valid;
    logic o_is_hit;

    logic [EW-1:0] eps_model;
    bit hit_fifo[$];
    int errors = 0;
    bit idle_on = 1'b1;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        for (int a = 0; a < 3; a++) begin
            drv.o[a] = '0; drv.d[a] = '0; drv.mn[a] = '0; drv.mx[a] = '0;
        end
    end

    ray_box_slab_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_hit_epsilon_we(i_hit_epsilon_we), .i_hit_epsilon(i_hit_epsilon),
        .i_origin_x(drv.o[0]), .i_origin_y(drv.o[1]), .i_origin_z(drv.o[2]),
        .i_dir_x(drv.d[0]), .i_dir_y(drv.d[1]), .i_dir_z(drv.d[2]),
        .i_box_min_x(drv.mn[0]), .i_box_min_y(drv.mn[1]), .i_box_min_z(drv.mn[2]),
        .i_box_max_x(drv.mx[0]), .i_box_max_y(drv.mx[1]), .i_box_max_z(drv.mx[2]),
        .o_valid(o_valid), .o_is_hit(o_is_hit)
    );

    // (plane - org) * 2^FB / den, truncated, saturated; lvl=1 flags 0/0
    function automatic dist_t plane_dist(longint plane, longint org, longint den);
        dist_t r;
        logic [127:0] num_m, q;
        logic [63:0] den_m;
        longint diff;
        bit neg;
        diff = plane - org;
        r.lvl = 0;
        if (den == 0) begin
            if (diff == 0) r.lvl = 1;
            r.v = (diff < 0) ? -MAXV : MAXV;
            return r;
        end
        num_m = 128'(diff < 0 ? -diff : diff) << FB;
        den_m = den < 0 ? 64'(-den) : 64'(den);
        q = num_m / den_m;
        if (q > 128'(MAXV)) q = 128'(MAXV);
        neg = (diff < 0) != (den < 0);
        r.v = neg ? -longint'(q[63:0]) : longint'(q[63:0]);
        return r;
    endfunction

    function automatic bit dist_gt(dist_t a, dist_t b);
        if (a.lvl != b.lvl) return a.lvl > b.lvl;
        return a.lvl == 0 && a.v > b.v;
    endfunction

    function automatic void axis_span(ray_box_t w, int a, output dist_t tn, output dist_t tf);
        longint o, d, pn, pf;
        o = w.o[a]; d = w.d[a];
        pn = d >= 0 ? longint'(w.mn[a]) : longint'(w.mx[a]);
        pf = d >= 0 ? longint'(w.mx[a]) : longint'(w.mn[a]);
        tn = plane_dist(pn, o, d);
        if (tn.lvl == 1) begin tn.lvl = -1; tn.v = 0; end
        tf = plane_dist(pf, o, d);
        if (tf.lvl == 1) tf.v = 0;
    endfunction

    function automatic bit predict_hit(ray_box_t w, logic [EW-1:0] eps);
        dist_t tmin, tmax, a, b, ne;
        axis_span(w, 0, tmin, tmax);
        axis_span(w, 1, a, b);
        if (dist_gt(tmin, b) || dist_gt(a, tmax)) return 1'b0;
        if (dist_gt(a, tmin)) tmin = a;
        if (dist_gt(tmax, b)) tmax = b;
        axis_span(w, 2, a, b);
        if (dist_gt(tmin, b) || dist_gt(a, tmax)) return 1'b0;
        if (dist_gt(tmax, b)) tmax = b;
        ne.lvl = 0;
        ne.v = -longint'(eps);
        return dist_gt(tmax, ne);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (hit_fifo.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual is_hit=%0b",
                         $time, o_is_hit);
                errors++;
            end else begin
                bit e;
                e = hit_fifo.pop_front();
                if (e !== o_is_hit) begin
                    $display("%0t: is_hit mismatch, expected %0b, actual %0b",
                             $time, e, o_is_hit);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [CW-1:0] rnd_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return '0;
            3: return CW'($urandom);
            default: return CW'(int'($urandom_range(0, 40 << FB)) - (20 << FB));
        endcase
    endfunction

    function automatic ray_box_t rnd_word();
        ray_box_t w;
        logic signed [CW-1:0] p, q;
        for (int a = 0; a < 3; a++) begin
            w.o[a] = rnd_coord();
            w.d[a] = ($urandom_range(0, 7) == 0) ? '0 : rnd_coord();
            p = rnd_coord(); q = rnd_coord();
            if ($urandom_range(0, 4) != 0 && p > q) begin
                w.mn[a] = q; w.mx[a] = p;
            end else begin
                w.mn[a] = p; w.mx[a] = q;
            end
        end
        // aim ray at box for many words so hits are common
        if ($urandom_range(0, 1)) begin
            for (int a = 0; a < 3; a++) begin
                w.mn[a] = CW'(int'($urandom_range(0, 8 << FB)) - (4 << FB));
                w.mx[a] = w.mn[a] + CW'($urandom_range(0, 4 << FB));
                w.o[a] = CW'(int'($urandom_range(0, 8 << FB)) - (4 << FB));
                w.d[a] = (w.mn[a] - w.o[a]) >>> $urandom_range(0, 3);
            end
        end
        return w;
    endfunction

    task automatic send_word(ray_box_t w, int hit_typed);
        bit e;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        drv <= w;
        i_start <= 1'b1;
        e = predict_hit(w, eps_model);
        if (hit_typed >= 0 && e != hit_typed[0]) begin
            $display("%0t: table row disagrees with predictor, expected %0d, actual %0b",
                     $time, hit_typed, e);
            errors++;
        end
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        hit_fifo.push_back(e);
    endtask

    task automatic set_eps(logic [EW-1:0] val);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (hit_fifo.size() != 0) @(posedge i_clk);
        i_hit_epsilon <= val;
        i_hit_epsilon_we <= 1'b1;
        @(posedge i_clk);
        i_hit_epsilon_we <= 1'b0;
        eps_model = val;
    endtask

    function automatic ray_box_t mk(logic signed [CW-1:0] o, logic signed [CW-1:0] d,
                                    logic signed [CW-1:0] mn, logic signed [CW-1:0] mx);
        ray_box_t w;
        for (int a = 0; a < 3; a++) begin
            w.o[a] = o; w.d[a] = d; w.mn[a] = mn; w.mx[a] = mx;
        end
        return w;
    endfunction

    initial begin
        test_row_t rows[$];
        test_row_t r;
        eps_model = rbs_pkg::EPS_RESET;
        r.w = mk(0, ONE, ONE, 2 * ONE); r.hit = 1; rows.push_back(r);
        r.w = mk(0, -ONE, ONE, 2 * ONE); r.hit = 0; rows.push_back(r);
        r.w = mk(0, 0, -ONE, ONE); r.hit = 1; rows.push_back(r);
        r.w = mk(0, 0, 0, 0); r.hit = 1; rows.push_back(r);
        r.w = mk(0, 0, ONE, 2 * ONE); r.hit = 1; rows.push_back(r);
        r.w = mk(MN, MX, MN, MX); r.hit = -1; rows.push_back(r);
        r.w = mk(MX, MN, MN, MX); r.hit = -1; rows.push_back(r);
        r.w = mk(MN, 1, MX, MX); r.hit = -1; rows.push_back(r);
        r.w = mk(MX, -1, MN, MN); r.hit = -1; rows.push_back(r);
        r.w = mk(-1, -1, -1, -1); r.hit = -1; rows.push_back(r);
        r.w = mk(0, ONE, 2 * ONE, ONE); r.hit = -1; rows.push_back(r);
        r.w = mk(0, ONE, -(ONE >>> 16) * 5, -(ONE >>> 16) * 3); r.hit = -1; rows.push_back(r);
        r.w = mk(0, ONE, -(ONE >>> 16) * 20, -(ONE >>> 16) * 10); r.hit = -1; rows.push_back(r);
        r.w = mk(0, ONE, ONE, 2 * ONE); r.w.d[1] = 0; r.w.mn[1] = 0; r.w.mx[1] = 0;
        r.hit = -1; rows.push_back(r);
        r.w = mk(0, ONE, ONE, 2 * ONE); r.w.d[2] = -ONE; r.hit = 0; rows.push_back(r);
        r.w = mk(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh5555_5555, 32'shAAAA_AAAA);
        r.hit = -1; rows.push_back(r);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[k]) send_word(rows[k].w, rows[k].hit);
        set_eps(17'h1FFFF);
        foreach (rows[k]) send_word(rows[k].w, -1);
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_eps('0);
                1: set_eps(17'd65536);
                2: set_eps(17'h0FFFF);
                3: set_eps(17'd1);
                4: set_eps(EW'($urandom_range(0, 65536)));
                default: begin set_eps(17'd7); idle_on = 1'b0; end
            endcase
            repeat (230) send_word(rnd_word(), -1);
        end
        i_start <= 1'b0;
        @(posedge i_clk);
        while (hit_fifo.size() != 0) @(posedge i_clk);
        repeat (LAT + 10) @(posedge i_clk);
        if (errors == 0)
            $display("ray_box_slab_test verification clean");
        else
            $display("ray_box_slab_test verification failed");
        $finish;
    end

    initial begin
        #200000;
        $display("ray_box_slab_test verification failed");
        $finish;
    end
endmodule

FILE: sim.f
sv/rbs_pkg.sv
sv/ray_box_slab_test.sv
sim/tb_ray_box_slab_test.sv
